// File: rtl/core/aesrh_pkg.sv
package aesrh_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned STATE_W = 2 * HALF_W;
    localparam int unsigned NBYTES  = STATE_W / 8;

    typedef logic [STATE_W-1:0] state_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [7:0]         byte_t;

    localparam half_t  IV_LOW   = 64'h5138_5012_8471_2094;
    localparam half_t  IV_HIGH  = 64'h3692_815C_1045_9385;
    localparam half_t  KEY_LOW  = 64'h0123_4567_89AB_CDEF;
    localparam half_t  KEY_HIGH = 64'hDEAD_BEEF_CAFE_BABE;
    localparam half_t  SENTINEL = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam state_t IV_STATE  = {IV_HIGH, IV_LOW};
    localparam state_t KEY_STATE = {KEY_HIGH, KEY_LOW};

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t xtime(input byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// File: rtl/core/aesrh_round.sv
module aesrh_round
    import aesrh_pkg::*;
(
    input  state_t state_in,
    output state_t state_out
);

    byte_t s_bytes [NBYTES];
    byte_t t_bytes [NBYTES];
    byte_t m_bytes [NBYTES];

    // State byte i is AES byte i: column i/4, row i%4.
    always_comb begin
        for (int i = 0; i < NBYTES; i++) begin
            s_bytes[i] = state_in[8*i +: 8];
        end
        // ShiftRows followed by SubBytes.
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t_bytes[r + 4*c] = SBOX[s_bytes[r + 4*((c + r) % 4)]];
            end
        end
    end

    always_comb begin
        byte_t a0;
        byte_t a1;
        byte_t a2;
        byte_t a3;
        byte_t x;
        for (int c = 0; c < 4; c++) begin
            a0 = t_bytes[4*c];
            a1 = t_bytes[4*c + 1];
            a2 = t_bytes[4*c + 2];
            a3 = t_bytes[4*c + 3];
            x  = a0 ^ a1 ^ a2 ^ a3;
            m_bytes[4*c]     = a0 ^ x ^ xtime(a0 ^ a1);
            m_bytes[4*c + 1] = a1 ^ x ^ xtime(a1 ^ a2);
            m_bytes[4*c + 2] = a2 ^ x ^ xtime(a2 ^ a3);
            m_bytes[4*c + 3] = a3 ^ x ^ xtime(a3 ^ a0);
        end
    end

    // AddRoundKey with the fixed key.
    always_comb begin
        for (int i = 0; i < NBYTES; i++) begin
            state_out[8*i +: 8] = m_bytes[i] ^ KEY_STATE[8*i +: 8];
        end
    end

endmodule

// File: rtl/core/aes_round_block_hash_top.sv
// AES-round block hash: a message is streamed in as 128-bit blocks, one request
// per block, with message byte 0 in the low byte of s_block_low. A request with
// s_first_block set restarts the 128-bit chaining state from the fixed IV and
// every block is XORed into the state and one AES encryption round with a fixed
// key follows, unless s_infinity_point is set. An s_last_block request gets a
// second round and returns the low 64 bits of the state as m_hash_value; the
// state keeps that value, so a following block not marked first continues from
// it. An s_infinity_point request returns all ones and leaves the state alone.
// The block takes one request per clock cycle while s_ready is high; the
// registered result appears in the cycle after acceptance. The state feedback
// path, two AES rounds in series on a last block, sets the cycle time. Requests
// with no result are taken even while one waits on m_ready; a result-producing
// request waits only while the single output register is full and not drained.
module aes_round_block_hash_top
    import aesrh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_low,
    input  logic [63:0] s_block_high,
    input  logic        s_first_block,
    input  logic        s_last_block,
    input  logic        s_infinity_point,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    half_t  hash_reg;
    half_t  hash_next;

    state_t base_state;
    state_t mixed_state;
    state_t round1_state;
    state_t round2_state;
    logic   accept;
    logic   has_result;

    // A request that produces a result needs the output register free, or
    // being emptied in this same cycle.
    assign has_result = s_last_block | s_infinity_point;
    assign s_ready    = !m_valid_reg || m_ready || !has_result;
    assign accept     = s_valid && s_ready;

    assign base_state  = s_first_block ? IV_STATE : state_reg;
    assign mixed_state = base_state ^ {s_block_high, s_block_low};

    aesrh_round u_round1 (
        .state_in  (mixed_state),
        .state_out (round1_state)
    );

    // The final round of a last block.
    aesrh_round u_round2 (
        .state_in  (round1_state),
        .state_out (round2_state)
    );

    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            if (s_infinity_point) begin
                hash_next    = SENTINEL;
                m_valid_next = 1'b1;
            end else if (s_last_block) begin
                state_next   = round2_state;
                hash_next    = round2_state[HALF_W-1:0];
                m_valid_next = 1'b1;
            end else begin
                state_next = round1_state;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IV_STATE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

    // A pending result is never overwritten by a new result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_valid_reg && !m_ready) |-> !has_result)
        else $error("result register overwritten while stalled");

    // An infinity request returns the sentinel next cycle and keeps the state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_infinity_point) |=>
            (m_valid && m_hash_value == SENTINEL && $stable(state_reg)))
        else $error("infinity request mishandled");

    // A last block leaves the emitted hash as the low half of the new state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_block && !s_infinity_point) |=>
            (m_valid && m_hash_value == state_reg[HALF_W-1:0]))
        else $error("hash does not match chaining state");

    // A request without a result never raises the output valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !(accept && has_result)) |=> !m_valid)
        else $error("spurious result");

endmodule
